>>> hw/rtl/plcm_pkg.sv
package plcm_pkg;

    localparam int unsigned QW = 16;      // Q1.15 value width
    localparam int unsigned STOP_W = 64;
    localparam int unsigned SEG_W = 3;

    localparam logic [3:0] CFG_STOP_COUNT   = 4'd0;
    localparam logic [3:0] CFG_BAKE_ENTRIES = 4'd1;
    localparam logic [3:0] CFG_STOP_BASE    = 4'd2;

    localparam logic [2:0]  STOP_COUNT_RESET   = 3'd2;
    localparam logic [12:0] BAKE_ENTRIES_RESET = 13'd256;
    localparam logic [63:0] STOP1_RESET        = 64'h8000_8000_8000_8000;

    typedef enum logic [1:0] {
        KIND_BLACK,
        KIND_STOP,
        KIND_INTERP
    } plcm_kind_t;

    typedef struct packed {
        logic        op;
        logic [15:0] position;
        logic [11:0] entry_index;
    } plcm_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } plcm_out_t;

    // classified item handed from front to back
    typedef struct packed {
        plcm_kind_t       kind;
        logic [SEG_W-1:0] seg;
        logic [QW-1:0]    dt;
        logic [QW-1:0]    w;
    } plcm_item_t;

endpackage

>>> hw/rtl/plcm_div.sv
module plcm_div #(
    parameter int unsigned DEN_W  = 16,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [DEN_W+plcm_pkg::QW-1:0]   num,
    input  logic [DEN_W-1:0]                den,
    input  logic [SIDE_W-1:0]               side,
    output logic                            out_valid,
    output logic [plcm_pkg::QW-1:0]         quo,
    output logic [SIDE_W-1:0]               out_side
);

    localparam int unsigned QW    = plcm_pkg::QW;
    localparam int unsigned NUM_W = DEN_W + QW;

    logic [NUM_W-1:0]  rem_reg  [QW];
    logic [DEN_W-1:0]  den_reg  [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [SIDE_W-1:0] side_reg [QW];
    logic              vld_reg  [QW];

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QW-1:0]     q_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [NUM_W-1:0]  trial;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;
        logic [QW-1:0]     q_next;

        if (k == 0) begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign q_in    = '0;
            assign side_in = side;
            assign vld_in  = in_valid;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            trial    = NUM_W'(den_in) << (QW - 1 - k);
            ge       = (rem_in >= trial);
            rem_next = ge ? (rem_in - trial) : rem_in;
            q_next   = q_in;
            q_next[QW-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> hw/rtl/plcm_front.sv
module plcm_front #(
    parameter int unsigned MAX_STOPS        = 6,
    parameter int unsigned MAX_BAKE_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  plcm_pkg::plcm_in_t            sample,
    output logic                          sample_stall,
    input  logic [2:0]                    stop_count,
    input  logic [12:0]                   bake_entries,
    input  logic [MAX_STOPS-1:0][63:0]    stops,
    output logic                          item_valid,
    output plcm_pkg::plcm_item_t          item,
    input  logic                          item_full
);

    localparam int unsigned QW     = plcm_pkg::QW;
    localparam int unsigned DW     = $clog2(MAX_BAKE_ENTRIES);
    localparam int unsigned SIDE_W = QW + 1;

    logic                 en;
    logic [12:0]          n_eff;
    logic [12:0]          nm1_wide;
    logic [DW-1:0]        nm1;
    logic [DW-1:0]        idx_c;
    logic                 use_div;
    logic [QW-1:0]        pos_side;
    logic                 d_valid;
    logic [QW-1:0]        d_quo;
    logic [SIDE_W-1:0]    d_side;
    logic [QW-1:0]        t;
    logic [2:0]           ns;
    logic [QW-1:0]        p_last;
    plcm_pkg::plcm_item_t cls_next;
    plcm_pkg::plcm_item_t cls_reg;
    logic                 cls_valid_reg;

    assign en           = !(cls_valid_reg && item_full);
    assign sample_stall = !en;

    always_comb
    begin
        if (bake_entries == 13'd0)
            n_eff = 13'd1;
        else if (bake_entries > 13'(MAX_BAKE_ENTRIES))
            n_eff = 13'(MAX_BAKE_ENTRIES);
        else
            n_eff = bake_entries;
        nm1_wide = n_eff - 13'd1;
        nm1      = nm1_wide[DW-1:0];
        if (13'(sample.entry_index) > nm1_wide)
            idx_c = nm1;
        else
            idx_c = DW'(sample.entry_index);
        use_div  = sample.op && (n_eff != 13'd1);
        pos_side = sample.op ? '0 : sample.position;
    end

    plcm_div #(
        .DEN_W  (DW),
        .SIDE_W (SIDE_W)
    ) u_bake_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .num       ((DW + QW)'({idx_c, 15'b0})),
        .den       (nm1),
        .side      ({use_div, pos_side}),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    // segment search; lowest matching segment wins
    always_comb
    begin
        t  = d_side[QW] ? d_quo : d_side[QW-1:0];
        ns = (stop_count > 3'(MAX_STOPS)) ? 3'(MAX_STOPS) : stop_count;
        p_last = '0;
        for (int j = 0; j < MAX_STOPS; j++)
        begin
            if (ns == 3'(j + 1))
                p_last = stops[j][63:48];
        end
        cls_next.kind = plcm_pkg::KIND_BLACK;
        cls_next.seg  = '0;
        cls_next.dt   = '0;
        cls_next.w    = '0;
        if (ns == 3'd0)
        begin
            cls_next.kind = plcm_pkg::KIND_BLACK;
        end
        else if (t <= stops[0][63:48])
        begin
            cls_next.kind = plcm_pkg::KIND_STOP;
        end
        else if (t >= p_last)
        begin
            cls_next.kind = plcm_pkg::KIND_STOP;
            cls_next.seg  = ns - 3'd1;
        end
        else
        begin
            for (int j = MAX_STOPS - 2; j >= 0; j--)
            begin
                if ((3'(j + 1) < ns) && (stops[j][63:48] <= t) && (t <= stops[j+1][63:48]))
                begin
                    cls_next.seg = 3'(j);
                    if (stops[j][63:48] == stops[j+1][63:48])
                    begin
                        cls_next.kind = plcm_pkg::KIND_STOP;
                    end
                    else
                    begin
                        cls_next.kind = plcm_pkg::KIND_INTERP;
                        cls_next.dt   = t - stops[j][63:48];
                        cls_next.w    = stops[j+1][63:48] - stops[j][63:48];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cls_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg <= cls_next;
        end
    end

    assign item_valid = cls_valid_reg;
    assign item       = cls_reg;

endmodule

>>> hw/rtl/plcm_fifo.sv
module plcm_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  plcm_pkg::plcm_item_t din,
    output logic                 full,
    input  logic                 pop,
    output plcm_pkg::plcm_item_t dout,
    output logic                 empty
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    plcm_pkg::plcm_item_t mem [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [PW:0]          count_reg;
    logic [PW:0]          count_next;

    assign full  = (count_reg == (PW + 1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/plcm_back.sv
module plcm_back #(
    parameter int unsigned MAX_STOPS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  plcm_pkg::plcm_item_t       item,
    output logic                       item_pop,
    input  logic [MAX_STOPS-1:0][63:0] stops,
    output logic                       color_valid,
    output plcm_pkg::plcm_out_t        color,
    input  logic                       color_stall
);

    localparam int unsigned QW     = plcm_pkg::QW;
    localparam int unsigned SEG_W  = plcm_pkg::SEG_W;
    localparam int unsigned SIDE_W = $bits(plcm_pkg::plcm_kind_t) + SEG_W;

    logic                    adv;
    logic                    is_interp;
    logic                    d_valid;
    logic [QW-1:0]           u;
    logic [SIDE_W-1:0]       d_side;
    plcm_pkg::plcm_kind_t    d_kind;
    logic [SEG_W-1:0]        d_seg;
    logic [63:0]             stop_a;
    logic [63:0]             stop_b;
    logic [2:0][QW-1:0]      c_next;
    logic [2:0][QW-1:0]      c_reg;
    logic                    c_valid_reg;
    logic [2:0][7:0]         byte_next;
    plcm_pkg::plcm_out_t     color_reg;
    logic                    color_valid_reg;

    assign adv      = !(color_valid_reg && color_stall);
    assign item_pop = adv && item_valid;
    assign is_interp = (item.kind == plcm_pkg::KIND_INTERP);

    plcm_div #(
        .DEN_W  (QW),
        .SIDE_W (SIDE_W)
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (item_valid),
        .num       (is_interp ? (2 * QW)'({item.dt, 15'b0}) : '0),
        .den       (is_interp ? item.w : QW'(1)),
        .side      ({item.kind, item.seg}),
        .out_valid (d_valid),
        .quo       (u),
        .out_side  (d_side)
    );

    assign d_kind = plcm_pkg::plcm_kind_t'(d_side[SIDE_W-1:SEG_W]);
    assign d_seg  = d_side[SEG_W-1:0];

    always_comb
    begin
        stop_a = '0;
        stop_b = '0;
        for (int j = 0; j < MAX_STOPS; j++)
        begin
            if (d_seg == SEG_W'(j))
                stop_a = stops[j];
            if ((j > 0) && (d_seg == SEG_W'(j - 1)))
                stop_b = stops[j];
        end
    end

    // lo*1.0 + u*(hi - lo), never negative
    for (genvar ch = 0; ch < 3; ch++) begin : g_lerp
        logic [QW-1:0]        a;
        logic [QW-1:0]        b;
        logic signed [QW:0]   diff;
        logic signed [2*QW+1:0] prod;
        logic signed [2*QW+1:0] sum;

        always_comb
        begin
            a    = stop_a[ch*QW +: QW];
            b    = stop_b[ch*QW +: QW];
            diff = $signed({1'b0, b}) - $signed({1'b0, a});
            prod = $signed({1'b0, u}) * diff;
            sum  = $signed({2'b0, a, 15'b0}) + prod;
            unique case (d_kind)
                plcm_pkg::KIND_INTERP: c_next[ch] = sum[30:15];
                plcm_pkg::KIND_STOP:   c_next[ch] = a;
                default:               c_next[ch] = '0;
            endcase
        end
    end

    // (c*255 + 16384) >> 15, saturated
    for (genvar ch = 0; ch < 3; ch++) begin : g_byte
        logic [24:0] scaled;

        always_comb
        begin
            scaled = {1'b0, c_reg[ch], 8'b0} - 25'(c_reg[ch]) + 25'd16384;
            byte_next[ch] = (scaled[24:23] != 2'b00) ? 8'hFF : scaled[22:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg     <= 1'b0;
            color_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg     <= d_valid;
            color_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg           <= c_next;
            color_reg.red   <= byte_next[2];
            color_reg.green <= byte_next[1];
            color_reg.blue  <= byte_next[0];
        end
    end

    assign color_valid = color_valid_reg;
    assign color       = color_reg;

endmodule

>>> hw/rtl/piecewise_linear_colormap_core.sv
// channel | direction | handshake           | payload
// sample  | in        | sample_valid/_stall | plcm_in_t: op, position, entry_index
// color   | out       | color_valid/_stall  | plcm_out_t: red, green, blue
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled. Each item
// passes through the bake-position divider, segment search, the queue, the
// fraction divider, interpolation and byte rounding, in that order.
// Reset clears control state and loads the configuration defaults; cfg_ready is
// always high. A stalled output freezes the back end only; the front keeps
// taking items until the four-entry queue fills, then stalls sample.
module piecewise_linear_colormap_core #(
    parameter int unsigned MAX_STOPS        = 6,
    parameter int unsigned MAX_BAKE_ENTRIES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  plcm_pkg::plcm_in_t  sample,
    output logic                color_valid,
    input  logic                color_stall,
    output plcm_pkg::plcm_out_t color,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic [2:0]                 stop_count_reg;
    logic [12:0]                bake_entries_reg;
    logic [MAX_STOPS-1:0][63:0] stop_reg;
    logic                       cfg_we;

    plcm_pkg::plcm_item_t       f_item;
    logic                       f_valid;
    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    plcm_pkg::plcm_item_t       q_item;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg   <= plcm_pkg::STOP_COUNT_RESET;
            bake_entries_reg <= plcm_pkg::BAKE_ENTRIES_RESET;
            for (int j = 0; j < MAX_STOPS; j++)
                stop_reg[j] <= (j == 1) ? plcm_pkg::STOP1_RESET : 64'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == plcm_pkg::CFG_STOP_COUNT)
                stop_count_reg <= cfg_data[2:0];
            if (cfg_index == plcm_pkg::CFG_BAKE_ENTRIES)
                bake_entries_reg <= cfg_data[12:0];
            for (int j = 0; j < MAX_STOPS; j++)
            begin
                if (cfg_index == plcm_pkg::CFG_STOP_BASE + 4'(j))
                    stop_reg[j] <= cfg_data;
            end
        end
    end

    plcm_front #(
        .MAX_STOPS        (MAX_STOPS),
        .MAX_BAKE_ENTRIES (MAX_BAKE_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_stall (sample_stall),
        .stop_count   (stop_count_reg),
        .bake_entries (bake_entries_reg),
        .stops        (stop_reg),
        .item_valid   (f_valid),
        .item         (f_item),
        .item_full    (q_full)
    );

    assign q_push = f_valid && !q_full;

    plcm_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (f_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    plcm_back #(
        .MAX_STOPS (MAX_STOPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (!q_empty),
        .item        (q_item),
        .item_pop    (q_pop),
        .stops       (stop_reg),
        .color_valid (color_valid),
        .color       (color),
        .color_stall (color_stall)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("queue read while empty");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (q_full && f_valid))
        else $error("front stalled with room in queue");
`endif

endmodule
